[src/vds_pkg.sv]
// ----------------------------------------------------------------------------
// vds_pkg
// Shared constants, types and helpers of the Verlet drag step pipeline.
// ----------------------------------------------------------------------------
package vds_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam logic [30:0] TS_RESET = 31'd1092;

	// Quotient bits of the drag divider; the quotient saturates at 2^33.
	localparam int QBITS = 34;
	localparam int DVD_W = 63;

	typedef struct packed {
		logic signed [31:0] np;
		logic signed [31:0] vel;
		logic signed [31:0] acc;
		logic signed [31:0] grav;
		logic [29:0]        hdt;
		logic               neg;
		logic               nodrag;
		logic               fault;
		logic               last;
	} side_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (x < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return x[31:0];
	endfunction

endpackage

[src/vds_div.sv]
// ----------------------------------------------------------------------------
// vds_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module vds_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_v,
	input  logic [vds_pkg::DVD_W-1:0]         dividend,
	input  logic [30:0]                       divisor,
	input  vds_pkg::side_t                    side_in,
	output logic                              out_v,
	output logic [vds_pkg::QBITS-1:0]         quot,
	output logic                              ovf,
	output vds_pkg::side_t                    side_out
);
	import vds_pkg::*;

	localparam int HI_W = DVD_W - QBITS;

	logic              vld_q [0:QBITS];
	logic [30:0]       rem_q [0:QBITS];
	logic [QBITS-1:0]  quo_q [0:QBITS];
	logic [DVD_W-1:0]  dvd_q [0:QBITS];
	logic [30:0]       dvs_q [0:QBITS];
	logic              ovf_q [0:QBITS];
	side_t             sd_q  [0:QBITS];

	// Entry stage: the upper dividend bits seed the remainder. If they already
	// reach the divisor, the quotient does not fit in QBITS bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q[0] <= 31'(dividend[DVD_W-1:QBITS]);
			quo_q[0] <= '0;
			dvd_q[0] <= dividend;
			dvs_q[0] <= divisor;
			ovf_q[0] <= 31'(dividend[DVD_W-1:QBITS]) >= divisor;
			sd_q[0]  <= side_in;
		end
	end

	for (genvar k = 1; k <= QBITS; k++) begin : g_stage
		logic [31:0] r2;
		logic        ge;

		assign r2 = {rem_q[k-1], dvd_q[k-1][QBITS-k]};
		assign ge = r2 >= {1'b0, dvs_q[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv) begin
				vld_q[k] <= vld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[k] <= ge ? 31'(r2 - {1'b0, dvs_q[k-1]}) : r2[30:0];
				quo_q[k] <= {quo_q[k-1][QBITS-2:0], ge};
				dvd_q[k] <= dvd_q[k-1];
				dvs_q[k] <= dvs_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
				sd_q[k]  <= sd_q[k-1];
			end
		end
	end

	assign out_v    = vld_q[QBITS];
	assign quot     = quo_q[QBITS];
	assign ovf      = ovf_q[QBITS] | (HI_W == 0);
	assign side_out = sd_q[QBITS];

endmodule

[src/verlet_drag_step.sv]
// ----------------------------------------------------------------------------
// verlet_drag_step
// One velocity-Verlet step with quadratic drag for one particle axis.
// ----------------------------------------------------------------------------
// Usage: each input item carries position, velocity, prior acceleration,
// gravity, drag coefficient and mass of one axis; each yields one result
// item with the new position, velocity and acceleration in signed fixed
// point, a mass fault flag and a copy of is_last.
// Both channels use valid and stall. The pipeline takes one item per cycle;
// unless the receiver stalls; it has 42 register stages: four front stages,
// the 35 stages of the bit-per-stage drag divider, and three back stages.
// The time step register is written through time_step_we/time_step_data and
// should only change while the pipeline is empty; it resets to about 1/60.
// Reset empties the pipeline. When the receiver stalls with a result waiting,
// the whole pipeline holds and in_stall rises in the same cycle, so no item
// is lost or repeated.
// ----------------------------------------------------------------------------
module verlet_drag_step #(
	parameter int FRAC_BITS = vds_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               time_step_we,
	input  logic [30:0]        time_step_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] position,
	input  logic signed [31:0] velocity,
	input  logic signed [31:0] prior_accel,
	input  logic signed [31:0] gravity,
	input  logic [30:0]        drag_coeff,
	input  logic [30:0]        particle_mass,
	input  logic               is_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] new_position,
	output logic signed [31:0] new_velocity,
	output logic signed [31:0] new_accel,
	output logic               mass_fault,
	output logic               end_of_run
);
	import vds_pkg::*;

	localparam int TW = 63 - FRAC_BITS;
	localparam logic [62:0] TMAX = (63'd1 << TW) - 63'd1;

	logic [30:0] dt_q;
	logic        adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= TS_RESET;
		end else if (time_step_we) begin
			dt_q <= time_step_data;
		end
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	assign adv      = !(vld_s7 && out_stall);
	assign in_stall = !adv;

	// Stage 1: capture and absolute velocity.
	logic signed [31:0] pos_s1, vel_s1, acc_s1, grav_s1;
	logic [30:0]        drag_s1, mass_s1, dt_s1;
	logic [29:0]        hdt_s1;
	logic [31:0]        vmag_s1;
	logic               last_s1, fault_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1   <= position;
			vel_s1   <= velocity;
			acc_s1   <= prior_accel;
			grav_s1  <= gravity;
			drag_s1  <= drag_coeff;
			mass_s1  <= particle_mass;
			dt_s1    <= dt_q;
			hdt_s1   <= dt_q[30:1];
			vmag_s1  <= velocity[31] ? 32'(-velocity) : 32'(velocity);
			last_s1  <= is_last;
			fault_s1 <= particle_mass == '0;
		end
	end

	// Stage 2: v*v, v*dt and dt*dt/2.
	logic signed [31:0] pos_s2, vel_s2, acc_s2, grav_s2;
	logic [30:0]        drag_s2, mass_s2;
	logic [29:0]        hdt_s2;
	logic [63:0]        vv_s2;
	logic signed [62:0] vdt_s2;
	logic [60:0]        dd_s2;
	logic               last_s2, fault_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s2   <= pos_s1;
			vel_s2   <= vel_s1;
			acc_s2   <= acc_s1;
			grav_s2  <= grav_s1;
			drag_s2  <= drag_s1;
			mass_s2  <= mass_s1;
			hdt_s2   <= hdt_s1;
			vv_s2    <= vmag_s1 * vmag_s1;
			vdt_s2   <= $signed(vel_s1) * $signed({1'b0, dt_s1});
			dd_s2    <= dt_s1 * hdt_s1;
			last_s2  <= last_s1;
			fault_s2 <= fault_s1;
		end
	end

	// Stage 3: saturate v*|v|, multiply by drag; saturate dt*dt/2.
	logic [63:0] vv_sh;
	logic [31:0] s_c;
	logic [60:0] dd_sh;

	assign vv_sh = vv_s2 >> FRAC_BITS;
	assign s_c   = (vv_sh > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vv_sh[31:0];
	assign dd_sh = dd_s2 >> FRAC_BITS;

	logic signed [31:0] pos_s3, vel_s3, acc_s3, grav_s3;
	logic [30:0]        mass_s3, hsq_s3;
	logic [29:0]        hdt_s3;
	logic [62:0]        tp_s3;
	logic signed [62:0] vdtf_s3;
	logic               last_s3, fault_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s3   <= pos_s2;
			vel_s3   <= vel_s2;
			acc_s3   <= acc_s2;
			grav_s3  <= grav_s2;
			mass_s3  <= mass_s2;
			hdt_s3   <= hdt_s2;
			tp_s3    <= drag_s2 * s_c;
			hsq_s3   <= (dd_sh > 61'h7FFF_FFFF) ? 31'h7FFF_FFFF : dd_sh[30:0];
			vdtf_s3  <= vdt_s2 >>> FRAC_BITS;
			last_s3  <= last_s2;
			fault_s3 <= fault_s2;
		end
	end

	// Stage 4: drag term numerator and a*dt*dt/2.
	logic [62:0]   tsh;
	logic [TW-1:0] t_c;

	assign tsh = tp_s3 >> (FRAC_BITS + 1);
	assign t_c = (tsh > TMAX) ? TMAX[TW-1:0] : tsh[TW-1:0];

	logic signed [31:0] pos_s4, vel_s4, acc_s4, grav_s4;
	logic [30:0]        mass_s4;
	logic [29:0]        hdt_s4;
	logic [62:0]        dvd_s4;
	logic signed [62:0] vdtf_s4, ahsq_s4;
	logic               last_s4, fault_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s4   <= pos_s3;
			vel_s4   <= vel_s3;
			acc_s4   <= acc_s3;
			grav_s4  <= grav_s3;
			mass_s4  <= mass_s3;
			hdt_s4   <= hdt_s3;
			dvd_s4   <= {t_c, {FRAC_BITS{1'b0}}};
			vdtf_s4  <= vdtf_s3;
			ahsq_s4  <= $signed(acc_s3) * $signed({1'b0, hsq_s3});
			last_s4  <= last_s3;
			fault_s4 <= fault_s3;
		end
	end

	logic signed [63:0] ahsqf;
	side_t              side_in, side_out;

	assign ahsqf = 64'(ahsq_s4 >>> FRAC_BITS);

	always_comb begin
		side_in.np     = sat32(64'(pos_s4) + 64'(vdtf_s4) + ahsqf);
		side_in.vel    = vel_s4;
		side_in.acc    = acc_s4;
		side_in.grav   = grav_s4;
		side_in.hdt    = hdt_s4;
		side_in.neg    = vel_s4[31];
		side_in.nodrag = fault_s4 || (vel_s4 == '0);
		side_in.fault  = fault_s4;
		side_in.last   = last_s4;
	end

	logic             div_v, div_ovf;
	logic [QBITS-1:0] div_q;

	vds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (vld_s4),
		.dividend (dvd_s4),
		.divisor  (mass_s4),
		.side_in  (side_in),
		.out_v    (div_v),
		.quot     (div_q),
		.ovf      (div_ovf),
		.side_out (side_out)
	);

	// Stage 5: signed drag term and new acceleration.
	localparam logic [QBITS-1:0] QSAT = QBITS'(1) << (QBITS - 1);

	logic [QBITS-1:0]   q_c;
	logic signed [35:0] dterm_c;

	assign q_c = (div_ovf || div_q > QSAT) ? QSAT : div_q;

	always_comb begin
		if (side_out.nodrag) begin
			dterm_c = '0;
		end else if (side_out.neg) begin
			dterm_c = -$signed({2'b00, q_c});
		end else begin
			dterm_c = $signed({2'b00, q_c});
		end
	end

	side_t              sd_s5;
	logic signed [31:0] na_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s5 <= side_out;
			na_s5 <= sat32(64'(side_out.grav) - 64'(dterm_c));
		end
	end

	// Stage 6: (a + new acceleration) * dt/2.
	side_t              sd_s6;
	logic signed [31:0] na_s6;
	logic signed [63:0] prod_s6;
	logic signed [32:0] asum_c;

	assign asum_c = 33'(sd_s5.acc) + 33'(na_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s6   <= sd_s5;
			na_s6   <= na_s5;
			prod_s6 <= asum_c * $signed({1'b0, sd_s5.hdt});
		end
	end

	// Stage 7: output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			new_position <= sd_s6.np;
			new_velocity <= sat32(64'(sd_s6.vel) + (prod_s6 >>> FRAC_BITS));
			new_accel    <= na_s6;
			mass_fault   <= sd_s6.fault;
			end_of_run   <= sd_s6.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= div_v;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	assign out_valid = vld_s7;

endmodule
